// ===== sv/q2rm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Widths, defaults and the matrix entry indices; no dependencies.
package q2rm_pkg;
    localparam int unsigned IN_WIDTH_DEF  = 16;
    localparam int unsigned FRAC_BITS_DEF = 14;
    localparam int unsigned NUM_ENTRIES   = 9;
    // matrix entry indices, row major
    localparam int unsigned M00 = 0, M01 = 1, M02 = 2, M10 = 3, M11 = 4,
                            M12 = 5, M20 = 6, M21 = 7, M22 = 8;
endpackage

// ===== sv/q2rm_div.sv =====
// Pipelined restoring divider for one matrix entry: round(|num|*2^F/n), negated when i_neg.
// One quotient bit per stage, then a rounding and sign stage; uses q2rm_pkg.
module q2rm_div #(
    parameter int unsigned NW = 34,
    parameter int unsigned F  = q2rm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic          i_neg,
    input  logic [NW-1:0] i_den,
    output logic [F+1:0]  o_q
);
    import q2rm_pkg::*;
    localparam int unsigned S = F + 2;

    logic [NW-1:0] r_r   [S];
    logic [NW-1:0] r_den [S];
    logic [F+1:0]  r_q   [S];
    logic          r_neg [S];
    logic [NW-1:0] n_r   [S];
    logic [F+1:0]  n_q   [S];

    // stage 0: integer bit; stages 1..F: fraction bits; stage F+1: round, sign
    always_comb begin
        n_r[0] = (i_num >= i_den) ? i_num - i_den : i_num;
        n_q[0] = {{(F+1){1'b0}}, i_num >= i_den};
        for (int s = 1; s < S; s++) begin
            if (r_r[s-1] >= r_den[s-1] - r_r[s-1]) begin
                n_r[s] = r_r[s-1] - (r_den[s-1] - r_r[s-1]);
                n_q[s] = {r_q[s-1][F:0], 1'b1};
            end else begin
                n_r[s] = {r_r[s-1][NW-2:0], 1'b0};
                n_q[s] = {r_q[s-1][F:0], 1'b0};
            end
            if (s == S-1) begin
                n_q[s] = r_q[s-1] + {{(F+1){1'b0}},
                         (r_r[s-1] >= r_den[s-1] - r_r[s-1])};
                if (r_neg[s-1]) n_q[s] = -n_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0] <= n_r[0]; r_q[0] <= n_q[0];
            r_den[0] <= i_den; r_neg[0] <= i_neg;
            for (int s = 1; s < S; s++) begin
                r_r[s] <= n_r[s]; r_q[s] <= n_q[s];
                r_den[s] <= r_den[s-1]; r_neg[s] <= r_neg[s-1];
            end
        end
    end

    assign o_q = r_q[S-1];
endmodule

// ===== sv/quaternion_to_rotation_matrix.sv =====
// Top level: quaternion (w,x,y,z) in, 3x3 rotation matrix in fixed point out.
// Uses q2rm_pkg and q2rm_div (one pipelined divider per matrix entry).
//
// Usage: input words on the s_axis group, tdata = {z,y,x,w} with w lowest.
// Result words on the m_axis group: tdata holds m00,m01,...,m22 from the
// lowest bits, each FRAC_BITS+2 bits signed; tuser is the zero quaternion
// flag. 1.0 is 2^FRAC_BITS. Throughput is one word per cycle unless the
// output stalls. Pipeline stages: magnitudes, products, sums, numerator
// magnitudes, then one divider stage per quotient bit plus a rounding stage.
// The whole pipeline advances together whenever the output stage is free
// or empty, so a stall on m_axis_tready holds every stage in place and
// back-pressures s_axis_tready; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears the valid bits only.
module quaternion_to_rotation_matrix #(
    parameter int unsigned IN_WIDTH  = q2rm_pkg::IN_WIDTH_DEF,
    parameter int unsigned FRAC_BITS = q2rm_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // w, x, y, z from bit 0 up
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]   m_axis_tdata,
    // zero_quat
    output logic                                   m_axis_tuser
);
    import q2rm_pkg::*;
    localparam int unsigned W   = IN_WIDTH;
    localparam int unsigned OW  = FRAC_BITS + 2;
    localparam int unsigned PW  = 2*W;          // product magnitude
    localparam int unsigned NW  = 2*W + 3;      // sums up to 4 products, x2
    localparam int unsigned LAT = FRAC_BITS + 6;
    localparam int unsigned ODW = ((9*OW+7)/8)*8;

    logic adv;
    logic [LAT-1:0] r_vld;
    assign adv = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    // stage 1: magnitudes, signs, halving when all even
    logic [W-1:0] a_mag [4];
    logic         a_neg [4];
    logic [W-1:0] r_m1 [4];
    logic         r_s1 [4];
    logic         r_z1;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_neg[i] = s_axis_tdata[i*W+W-1];
            a_mag[i] = a_neg[i] ? W'(-s_axis_tdata[i*W +: W]) : s_axis_tdata[i*W +: W];
        end
    end
    // magnitude of -2^(W-1) needs W bits unsigned: fine
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r_m1[i] <= ((a_mag[0][0] | a_mag[1][0] | a_mag[2][0] | a_mag[3][0]) == 1'b0)
                           ? (a_mag[i] >> 1) : a_mag[i];
                r_s1[i] <= a_neg[i] && (a_mag[i] != '0);
            end
            r_z1 <= (a_mag[0] | a_mag[1] | a_mag[2] | a_mag[3]) == '0;
        end
    end

    // stage 2: ten products (signed, as magnitude-width signed values)
    // order: ww xx yy zz xy wz xz wy yz wx
    logic signed [PW:0] r_p2 [10];
    logic               r_z2;
    logic [1:0] pi [10];
    logic [1:0] pj [10];
    always_comb begin
        pi = '{2'd0,2'd1,2'd2,2'd3,2'd1,2'd0,2'd1,2'd0,2'd2,2'd0};
        pj = '{2'd0,2'd1,2'd2,2'd3,2'd2,2'd3,2'd3,2'd2,2'd3,2'd1};
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 10; k++) begin
                r_p2[k] <= (r_s1[pi[k]] ^ r_s1[pj[k]])
                    ? -$signed({1'b0, PW'(r_m1[pi[k]]) * PW'(r_m1[pj[k]])})
                    :  $signed({1'b0, PW'(r_m1[pi[k]]) * PW'(r_m1[pj[k]])});
            end
            r_z2 <= r_z1;
        end
    end

    // stage 3: n and the nine signed numerators
    logic signed [NW-1:0] r_nm3 [NUM_ENTRIES];
    logic [NW-1:0]        r_n3;
    logic                 r_z3;
    logic signed [NW-1:0] e [10];
    always_comb for (int k = 0; k < 10; k++) e[k] = NW'(r_p2[k]);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n3      <= e[0] + e[1] + e[2] + e[3];
            r_nm3[M00] <= e[0] + e[1] - e[2] - e[3];
            r_nm3[M11] <= e[0] - e[1] + e[2] - e[3];
            r_nm3[M22] <= e[0] - e[1] - e[2] + e[3];
            r_nm3[M01] <= (e[4] - e[5]) <<< 1;
            r_nm3[M02] <= (e[6] + e[7]) <<< 1;
            r_nm3[M10] <= (e[4] + e[5]) <<< 1;
            r_nm3[M12] <= (e[8] - e[9]) <<< 1;
            r_nm3[M20] <= (e[6] - e[7]) <<< 1;
            r_nm3[M21] <= (e[8] + e[9]) <<< 1;
            r_z3 <= r_z2;
        end
    end

    // stage 4: magnitude and sign of each numerator
    logic [NW-1:0] r_mag4 [NUM_ENTRIES];
    logic          r_neg4 [NUM_ENTRIES];
    logic [NW-1:0] r_n4;
    logic          r_z4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                r_neg4[k] <= r_nm3[k][NW-1];
                r_mag4[k] <= r_nm3[k][NW-1] ? NW'(-r_nm3[k]) : NW'(r_nm3[k]);
            end
            r_n4 <= r_z3 ? NW'(1) : r_n3;
            r_z4 <= r_z3;
        end
    end

    // divider stages (FRAC_BITS+2 of them)
    logic [OW-1:0] q [NUM_ENTRIES];
    for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_div
        q2rm_div #(.NW(NW), .F(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_mag4[k]),
            .i_neg (r_neg4[k]),
            .i_den (r_n4),
            .o_q   (q[k])
        );
    end

    // zero flag delay alongside the dividers
    logic [OW-1:0] r_zd;
    always_ff @(posedge i_clk) begin
        if (adv) r_zd <= {r_zd[OW-2:0], r_z4};
    end

    // output: identity for the zero quaternion
    logic [ODW-1:0] n_tdata;
    always_comb begin
        n_tdata = '0;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (r_zd[OW-1])
                n_tdata[k*OW +: OW] = (k == M00 || k == M11 || k == M22)
                                      ? OW'(1) << FRAC_BITS : '0;
            else
                n_tdata[k*OW +: OW] = q[k];
        end
    end
    assign m_axis_tdata  = n_tdata;
    assign m_axis_tuser  = r_zd[OW-1];
    assign m_axis_tvalid = r_vld[LAT-1];
endmodule
